### hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the TLB and page table translator.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned NFREE_W = 9;
  localparam int unsigned COUNT_W = 32;

  typedef struct packed {
    logic clear_step;
    logic load_addr;
    logic pt_read;
    logic finish_hit;
    logic finish_miss;
  } ptt_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic tlb_match;
    logic out_free;
  } ptt_status_t;

endpackage

### hdl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer for the translator: page table clearing pass, TLB lookup and
// page table miss handling.
// ----------------------------------------------------------------------------
module ptt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptt_pkg::ptt_status_t st,
  output ptt_pkg::ptt_cmd_t    cmd
);

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    LOOKUP,
    MISS
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = IDLE;
        end
      end
      IDLE: begin
        if (in_valid) begin
          cmd.load_addr = 1'b1;
          state_next    = LOOKUP;
        end
      end
      LOOKUP: begin
        cmd.pt_read = 1'b1;
        if (!st.tlb_match) begin
          state_next = MISS;
        end else if (st.out_free) begin
          cmd.finish_hit = 1'b1;
          state_next     = IDLE;
        end
      end
      MISS: begin
        if (st.out_free) begin
          cmd.finish_miss = 1'b1;
          state_next      = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign in_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/ptt_datapath.sv
// ----------------------------------------------------------------------------
// ptt_datapath
// Address register, TLB, page table memory, frame allocator, counters and
// the result register of the translator.
// ----------------------------------------------------------------------------
module ptt_datapath #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 8,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ptt_pkg::ptt_cmd_t                  cmd,
  output ptt_pkg::ptt_status_t               st,
  input  logic [ptt_pkg::ADDR_W-1:0]         logical_address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptt_pkg::ADDR_W-1:0]         physical_address,
  output logic [ptt_pkg::FRAME_W-1:0]        frame_number,
  output logic                               tlb_hit,
  output logic                               page_fault,
  output logic [ptt_pkg::COUNT_W-1:0]        hits_so_far,
  output logic [ptt_pkg::COUNT_W-1:0]        faults_so_far
);

  localparam int unsigned PAGE_COUNT = 1 << PAGE_BITS;
  localparam int unsigned SLOT_W     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned PAGE_EXT_W = (PAGE_BITS > ptt_pkg::TAG_W) ? PAGE_BITS
                                                                      : ptt_pkg::TAG_W;
  localparam int unsigned PHYS_W     = 2 * ptt_pkg::ADDR_W;
  localparam int unsigned ENTRY_W    = ptt_pkg::FRAME_W + 1;

  logic [ptt_pkg::ADDR_W-1:0]   addr;
  logic [2*ptt_pkg::ADDR_W-1:0] addr_shifted;
  logic [PAGE_BITS-1:0]         page;
  logic [PAGE_EXT_W-1:0]        page_ext;
  logic [ptt_pkg::TAG_W-1:0]    tag;
  logic [OFFSET_BITS-1:0]       offset;

  logic [ptt_pkg::TAG_W-1:0]    tlb_tag   [TLB_ENTRIES];
  logic [ptt_pkg::FRAME_W-1:0]  tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]       tlb_valid;
  logic [SLOT_W-1:0]            victim;
  logic                         match;
  logic [ptt_pkg::FRAME_W-1:0]  match_frame;

  logic [ENTRY_W-1:0]           pt_mem [PAGE_COUNT];
  logic [ENTRY_W-1:0]           pt_rd_data;
  logic                         pt_we;
  logic [PAGE_BITS-1:0]         pt_waddr;
  logic [ENTRY_W-1:0]           pt_wdata;
  logic [PAGE_BITS-1:0]         clear_cnt;

  logic [ptt_pkg::NFREE_W-1:0]  next_free;
  logic [ptt_pkg::COUNT_W-1:0]  hit_count;
  logic [ptt_pkg::COUNT_W-1:0]  fault_count;

  logic                         miss_fault;
  logic [ptt_pkg::FRAME_W-1:0]  miss_frame;
  logic [ptt_pkg::FRAME_W-1:0]  result_frame;
  logic [PHYS_W-1:0]            phys_full;
  logic                         out_free;

  assign addr_shifted = {{ptt_pkg::ADDR_W{1'b0}}, addr} >> OFFSET_BITS;
  assign page         = addr_shifted[PAGE_BITS-1:0];
  assign page_ext     = PAGE_EXT_W'(page);
  assign tag          = page_ext[ptt_pkg::TAG_W-1:0];
  assign offset       = addr[OFFSET_BITS-1:0];

  always_comb begin
    match       = 1'b0;
    match_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!match && tlb_valid[i] && (tlb_tag[i] == tag)) begin
        match       = 1'b1;
        match_frame = tlb_frame[i];
      end
    end
  end

  assign miss_fault   = !pt_rd_data[ENTRY_W-1];
  assign miss_frame   = miss_fault ? next_free[ptt_pkg::FRAME_W-1:0]
                                   : pt_rd_data[ptt_pkg::FRAME_W-1:0];
  assign result_frame = cmd.finish_hit ? match_frame : miss_frame;
  assign phys_full    = PHYS_W'({result_frame, offset});

  assign pt_we    = cmd.clear_step || (cmd.finish_miss && miss_fault);
  assign pt_waddr = cmd.clear_step ? clear_cnt : page;
  assign pt_wdata = cmd.clear_step ? '0 : {1'b1, next_free[ptt_pkg::FRAME_W-1:0]};

  assign out_free      = !out_valid || out_ready;
  assign st.out_free   = out_free;
  assign st.tlb_match  = match;
  assign st.clear_last = (clear_cnt == {PAGE_BITS{1'b1}});

  assign hits_so_far   = hit_count;
  assign faults_so_far = fault_count;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (cmd.pt_read) begin
      pt_rd_data <= pt_mem[page];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_addr) begin
      addr <= logical_address;
    end
    if (cmd.finish_miss) begin
      tlb_tag[victim]   <= tag;
      tlb_frame[victim] <= miss_frame;
    end
    if (cmd.finish_hit || cmd.finish_miss) begin
      physical_address <= phys_full[ptt_pkg::ADDR_W-1:0];
      frame_number     <= result_frame;
      tlb_hit          <= cmd.finish_hit;
      page_fault       <= cmd.finish_miss && miss_fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid   <= '0;
      victim      <= '0;
      next_free   <= '0;
      hit_count   <= '0;
      fault_count <= '0;
      clear_cnt   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (cmd.finish_hit && (hit_count != {ptt_pkg::COUNT_W{1'b1}})) begin
        hit_count <= hit_count + 1'b1;
      end
      if (cmd.finish_miss) begin
        tlb_valid[victim] <= 1'b1;
        if (victim == SLOT_W'(TLB_ENTRIES - 1)) begin
          victim <= '0;
        end else begin
          victim <= victim + 1'b1;
        end
        if (miss_fault) begin
          next_free <= next_free + 1'b1;
          if (fault_count != {ptt_pkg::COUNT_W{1'b1}}) begin
            fault_count <= fault_count + 1'b1;
          end
        end
      end
      if (cmd.finish_hit || cmd.finish_miss) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_single_finish: assert property (@(posedge clk) disable iff (rst)
    !(cmd.finish_hit && cmd.finish_miss))
    else $error("hit and miss completion in the same cycle");

  a_hit_needs_match: assert property (@(posedge clk) disable iff (rst)
    cmd.finish_hit |-> match)
    else $error("hit completion without a TLB match");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish_hit || cmd.finish_miss) |-> out_free)
    else $error("result register overwritten before it was taken");

  a_alloc_only_on_fault: assert property (@(posedge clk) disable iff (rst)
    !(cmd.finish_miss && miss_fault) |=> $stable(next_free))
    else $error("free frame pointer moved without a page fault");

  a_hit_not_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault))
    else $error("result flags both a TLB hit and a page fault");

endmodule

### hdl/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical address translation with a FIFO-replaced TLB in
// front of a demand-allocated page table.
// ----------------------------------------------------------------------------
// Each input transaction carries a 16-bit logical address; each produces
// exactly one output transaction with the physical address, the frame, the
// TLB hit and page fault flags and the saturating hit and fault counts.
// Both channels use valid and ready handshakes.
// A TLB hit loads the result register from the LOOKUP state; a TLB miss
// goes on to the MISS state, because the page table is a synchronous RAM
// with one registered read port, and on a page fault writes the new entry there.
// One address is in flight at a time, so the block takes no new address
// until the last one has been loaded into the output register.
// After reset the page table is cleared one entry per cycle, all
// 2**PAGE_BITS entries (256 by default); in_ready stays low during that pass.
// The result sits in an output register. While the receiver stalls, the
// block still accepts one new transaction and translates it up to the point
// where it needs the output register, then holds until that is taken.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 8,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ptt_pkg::ADDR_W-1:0]  logical_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ptt_pkg::ADDR_W-1:0]  physical_address,
  output logic [ptt_pkg::FRAME_W-1:0] frame_number,
  output logic                        tlb_hit,
  output logic                        page_fault,
  output logic [ptt_pkg::COUNT_W-1:0] hits_so_far,
  output logic [ptt_pkg::COUNT_W-1:0] faults_so_far
);

  ptt_pkg::ptt_cmd_t    cmd;
  ptt_pkg::ptt_status_t st;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ptt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_BITS   (PAGE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .logical_address  (logical_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .physical_address (physical_address),
    .frame_number     (frame_number),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hits_so_far      (hits_so_far),
    .faults_so_far    (faults_so_far)
  );

endmodule

### test/ptt_translation_checker.sv
// ----------------------------------------------------------------------------
// ptt_translation_checker
// Watches both channels of the translator, keeps its own TLB and page table
// state, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module ptt_translation_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [ptt_pkg::ADDR_W-1:0]  logical_address,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [ptt_pkg::ADDR_W-1:0]  physical_address,
  input  logic [ptt_pkg::FRAME_W-1:0] frame_number,
  input  logic                        tlb_hit,
  input  logic                        page_fault,
  input  logic [ptt_pkg::COUNT_W-1:0] hits_so_far,
  input  logic [ptt_pkg::COUNT_W-1:0] faults_so_far,
  output int                          mismatch_count,
  output int                          translations_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TLB_SLOTS  = 16;
  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned PAGE_W     = ptt_pkg::ADDR_W - OFFSET_W;
  localparam int unsigned PAGE_COUNT = 1 << PAGE_W;
  localparam int unsigned SLOT_W     = $clog2(TLB_SLOTS);
  localparam int unsigned REPORT_W   = ptt_pkg::COUNT_W;

  typedef struct packed {
    logic [ptt_pkg::ADDR_W-1:0]  physical_address;
    logic [ptt_pkg::FRAME_W-1:0] frame;
    logic                        hit;
    logic                        fault;
    logic [ptt_pkg::COUNT_W-1:0] hits;
    logic [ptt_pkg::COUNT_W-1:0] faults;
  } translation_t;

  logic [ptt_pkg::TAG_W-1:0]   slot_tag   [TLB_SLOTS];
  logic [ptt_pkg::FRAME_W-1:0] slot_frame [TLB_SLOTS];
  logic                        slot_valid [TLB_SLOTS];
  logic [SLOT_W-1:0]           victim_slot;
  logic [ptt_pkg::FRAME_W-1:0] page_frame  [PAGE_COUNT];
  logic                        page_mapped [PAGE_COUNT];
  logic [ptt_pkg::NFREE_W-1:0] free_frame;
  logic [ptt_pkg::COUNT_W-1:0] hit_total;
  logic [ptt_pkg::COUNT_W-1:0] fault_total;

  translation_t expected_translations [$];
  int mismatches = 0;
  int pending = 0;

  assign mismatch_count       = mismatches;
  assign translations_pending = pending;

  function automatic logic [ptt_pkg::COUNT_W-1:0] bump(logic [ptt_pkg::COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic translation_t translate_address(logic [ptt_pkg::ADDR_W-1:0] la);
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    translation_t        t;
    page   = la[ptt_pkg::ADDR_W-1 -: PAGE_W];
    offset = la[OFFSET_W-1:0];
    t      = '0;
    for (int i = 0; i < TLB_SLOTS; i++) begin
      if (!t.hit && slot_valid[i] && slot_tag[i] == page) begin
        t.hit   = 1'b1;
        t.frame = slot_frame[i];
      end
    end
    if (t.hit) begin
      hit_total = bump(hit_total);
    end else begin
      if (!page_mapped[page]) begin
        page_frame[page]  = free_frame[ptt_pkg::FRAME_W-1:0];
        page_mapped[page] = 1'b1;
        free_frame        = free_frame + 1'b1;
        fault_total       = bump(fault_total);
        t.fault           = 1'b1;
      end
      t.frame                 = page_frame[page];
      slot_tag[victim_slot]   = page;
      slot_frame[victim_slot] = t.frame;
      slot_valid[victim_slot] = 1'b1;
      victim_slot             = victim_slot + 1'b1;
    end
    t.physical_address = {t.frame, offset};
    t.hits             = hit_total;
    t.faults           = fault_total;
    return t;
  endfunction

  task automatic clear_model();
    for (int i = 0; i < TLB_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
    end
    for (int p = 0; p < PAGE_COUNT; p++) begin
      page_mapped[p] = 1'b0;
    end
    victim_slot = '0;
    free_frame  = '0;
    hit_total   = '0;
    fault_total = '0;
    expected_translations.delete();
  endtask

  task automatic report_mismatch(string field, logic [REPORT_W-1:0] got,
                                 logic [REPORT_W-1:0] want);
    $display("%0t ns ptt_translation_checker: %s mismatch, got 0x%0h, expected 0x%0h",
             $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    translation_t want;
    if (rst) begin
      clear_model();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_translations.size() == 0) begin
          report_mismatch("unexpected transaction", REPORT_W'(physical_address), '0);
        end else begin
          want = expected_translations.pop_front();
          if (physical_address !== want.physical_address) begin
            report_mismatch("physical_address", REPORT_W'(physical_address),
                            REPORT_W'(want.physical_address));
          end
          if (frame_number !== want.frame) begin
            report_mismatch("frame_number", REPORT_W'(frame_number), REPORT_W'(want.frame));
          end
          if (tlb_hit !== want.hit) begin
            report_mismatch("tlb_hit", REPORT_W'(tlb_hit), REPORT_W'(want.hit));
          end
          if (page_fault !== want.fault) begin
            report_mismatch("page_fault", REPORT_W'(page_fault), REPORT_W'(want.fault));
          end
          if (hits_so_far !== want.hits) begin
            report_mismatch("hits_so_far", hits_so_far, want.hits);
          end
          if (faults_so_far !== want.faults) begin
            report_mismatch("faults_so_far", faults_so_far, want.faults);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_translations.push_back(translate_address(logical_address));
      end
    end
    pending <= expected_translations.size();
  end

endmodule

### test/tb_tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tb_tlb_page_table_translator
// Drives logical addresses into the translator with random gaps on both
// channels, a long receiver stall, and a mix of hot working sets, random
// pages and page sweeps; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OFFSET_W       = 8;
  localparam int unsigned PAGE_W         = ptt_pkg::ADDR_W - OFFSET_W;
  localparam int          RANDOM_ITEMS   = 1600;
  localparam int          HOLD_CYCLES    = 160;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          WATCHDOG_LIMIT = 2000;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [ptt_pkg::ADDR_W-1:0]  logical_address;
  logic                        out_valid;
  logic                        out_ready;
  logic [ptt_pkg::ADDR_W-1:0]  physical_address;
  logic [ptt_pkg::FRAME_W-1:0] frame_number;
  logic                        tlb_hit;
  logic                        page_fault;
  logic [ptt_pkg::COUNT_W-1:0] hits_so_far;
  logic [ptt_pkg::COUNT_W-1:0] faults_so_far;

  int                mismatch_count;
  int                translations_pending;
  int                idle_cycles = 0;
  logic              hold_armed;
  logic [PAGE_W-1:0] sweep_page = '0;
  logic [PAGE_W-1:0] hot_base = 8'h40;
  int                hot_span = 7;

  always #2 clk = ~clk;

  tlb_page_table_translator u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .logical_address  (logical_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .physical_address (physical_address),
    .frame_number     (frame_number),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hits_so_far      (hits_so_far),
    .faults_so_far    (faults_so_far)
  );

  ptt_translation_checker u_checker (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .logical_address      (logical_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .physical_address     (physical_address),
    .frame_number         (frame_number),
    .tlb_hit              (tlb_hit),
    .page_fault           (page_fault),
    .hits_so_far          (hits_so_far),
    .faults_so_far        (faults_so_far),
    .mismatch_count       (mismatch_count),
    .translations_pending (translations_pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [ptt_pkg::ADDR_W-1:0] next_address();
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    int                  pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      hot_base = PAGE_W'($urandom);
      hot_span = $urandom_range(0, 1) ? 7 : 23;
    end
    if (pick < 65) begin
      page = hot_base + PAGE_W'($urandom_range(0, hot_span));
    end else if (pick < 85) begin
      page = PAGE_W'($urandom);
    end else begin
      page       = sweep_page;
      sweep_page = sweep_page + 1'b1;
    end
    case ($urandom_range(0, 7))
      0: offset = '0;
      1: offset = '1;
      default: offset = OFFSET_W'($urandom);
    endcase
    return {page, offset};
  endfunction

  task automatic send_address(logic [ptt_pkg::ADDR_W-1:0] addr, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    logical_address <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    logical_address <= '0;
    hold_armed      <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Corner pages and offsets, a repeat hit, then enough new pages to wrap
    // the replacement pointer and evict the first entries.
    send_address(16'h0000, pick_gap());
    send_address(16'h00FF, pick_gap());
    send_address(16'hFFFF, pick_gap());
    send_address(16'hFF00, pick_gap());
    send_address(16'h8055, pick_gap());
    send_address(16'h7FAA, pick_gap());
    for (int p = 1; p <= 14; p++) begin
      send_address({p[PAGE_W-1:0], 8'h5A ^ p[7:0]}, pick_gap());
    end
    send_address(16'h0012, pick_gap());
    send_address(16'hFF34, pick_gap());
    send_address(16'h0E00, pick_gap());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 700) begin
        hold_armed <= 1'b1;
      end
      send_address(next_address(), (n % 250 < 50) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (translations_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_tlb_page_table_translator: done, clean");
    end else begin
      $display("tb_tlb_page_table_translator: done, errors");
    end
    $finish;
  end

  initial begin
    int stall;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_armed && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(40, 80)) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_tlb_page_table_translator: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
